@@ rtl/wwvb_time_code_frame_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// WWVB frame encoder assertion macros
// Shared property wrappers for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef WWVB_TIME_CODE_FRAME_ENCODER_DEFINES_SVH
`define WWVB_TIME_CODE_FRAME_ENCODER_DEFINES_SVH

// same-cycle implication
`define WTC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define WTC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/wtc_pkg.sv @@
// ----------------------------------------------------------------------------
// WWVB time code package
// Types, constants and helper functions shared by the frame encoder.
// ----------------------------------------------------------------------------
package wtc_pkg;

   localparam int FRAME_LEN   = 60;
   localparam int IDX_W       = 6;
   localparam int MS_W        = 10;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [IDX_W-1:0] LAST_SEC = 6'd59;

   // year / 100 as (year * 5243) >> 19, exact for 14-bit years
   localparam int YEAR_W      = 14;
   localparam int RECIP_PROD_W = 27;
   localparam int RECIP_SHIFT = 19;
   localparam int CENT_W      = 8;
   localparam logic [RECIP_PROD_W-1:0] YEAR_RECIP = 27'd5243;

   localparam logic [MS_W-1:0] MS_SHORT = 10'd200;
   localparam logic [MS_W-1:0] MS_HALF  = 10'd500;
   localparam logic [MS_W-1:0] MS_LONG  = 10'd800;

   typedef enum logic [1:0] {
      SYM_ZERO = 2'd0,
      SYM_ONE  = 2'd1,
      SYM_MARK = 2'd2
   } symbol_type;

   typedef struct packed {
      logic                 valid;
      logic [FRAME_LEN-1:0] ones;
   } frame_type;

   function automatic logic [8:0] days_before(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd0:    d = 9'd0;
         4'd1:    d = 9'd31;
         4'd2:    d = 9'd59;
         4'd3:    d = 9'd90;
         4'd4:    d = 9'd120;
         4'd5:    d = 9'd151;
         4'd6:    d = 9'd181;
         4'd7:    d = 9'd212;
         4'd8:    d = 9'd243;
         4'd9:    d = 9'd273;
         4'd10:   d = 9'd304;
         default: d = 9'd334;
      endcase
      return d;
   endfunction

   // tens digit of a 7-bit value by threshold count
   function automatic logic [3:0] div10(input logic [6:0] x);
      logic [3:0] t;
      t = 4'd0;
      for (int k = 1; k <= 12; k++) begin
         if (x >= 7'(10 * k)) begin
            t = t + 4'd1;
         end
      end
      return t;
   endfunction

   function automatic logic is_marker(input logic [IDX_W-1:0] sec);
      return (sec == 6'd0) || (sec == 6'd9) || (sec == 6'd19) || (sec == 6'd29) ||
             (sec == 6'd39) || (sec == 6'd49) || (sec == 6'd59);
   endfunction

endpackage

@@ rtl/wtc_front.sv @@
// ----------------------------------------------------------------------------
// WWVB front end
// Accepts a UTC time, derives BCD fields, day of year and leap flag over two
// register stages, and pushes a 60-bit map of one-valued seconds.
// ----------------------------------------------------------------------------
module wtc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [39:0]                   req_tdata,
   output wtc_pkg::frame_type            push,
   input  logic                          queue_full
);

   // stage 1
   logic                          s1_valid_ff;
   logic [wtc_pkg::CENT_W-1:0]    s1_cent_ff, s1_cent_in;
   logic [wtc_pkg::YEAR_W-1:0]    s1_year_ff;
   logic [8:0]                    s1_doy_base_ff, s1_doy_base_in;
   logic                          s1_past_feb_ff, s1_past_feb_in;
   logic [5:0]                    s1_minute_ff;
   logic [4:0]                    s1_hour_ff;
   logic [1:0]                    s1_dst_ff;
   // stage 2
   logic                          s2_valid_ff;
   logic [6:0]                    s2_yy_ff, s2_yy_in;
   logic                          s2_leap_ff, s2_leap_in;
   logic [8:0]                    s2_doy_ff, s2_doy_in;
   logic [5:0]                    s2_minute_ff;
   logic [4:0]                    s2_hour_ff;
   logic [1:0]                    s2_dst_ff;

   logic en1, en2, push_ok;

   logic [5:0]                         in_minute;
   logic [4:0]                         in_hour;
   logic [3:0]                         in_month, month_clamp;
   logic [4:0]                         in_day;
   logic [wtc_pkg::YEAR_W-1:0]         in_year;
   logic [1:0]                         in_dst;
   logic [wtc_pkg::RECIP_PROD_W-1:0]   recip_prod;
   logic [wtc_pkg::YEAR_W:0]           cent_x100, year_rem;

   assign in_minute = req_tdata[5:0];
   assign in_hour   = req_tdata[10:6];
   assign in_month  = req_tdata[14:11];
   assign in_day    = req_tdata[19:15];
   assign in_year   = req_tdata[33:20];
   assign in_dst    = req_tdata[35:34];

   assign push_ok    = s2_valid_ff && !queue_full;
   assign en2        = !s2_valid_ff || push_ok;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;

   always_comb begin
      month_clamp     = (in_month > 4'd11) ? 4'd11 : in_month;
      recip_prod      = wtc_pkg::RECIP_PROD_W'(in_year) * wtc_pkg::YEAR_RECIP;
      s1_cent_in      = recip_prod[wtc_pkg::RECIP_PROD_W-1:wtc_pkg::RECIP_SHIFT];
      s1_doy_base_in  = wtc_pkg::days_before(month_clamp) + 9'(in_day);
      s1_past_feb_in  = (month_clamp > 4'd1);
   end

   always_comb begin
      cent_x100  = (wtc_pkg::YEAR_W+1)'(s1_cent_ff) * (wtc_pkg::YEAR_W+1)'(100);
      year_rem   = (wtc_pkg::YEAR_W+1)'(s1_year_ff) - cent_x100;
      s2_yy_in   = year_rem[6:0];
      // divisible by 100: leap only when the century count is divisible by 4
      s2_leap_in = (s2_yy_in == 7'd0) ? (s1_cent_ff[1:0] == 2'b00)
                                      : (s1_year_ff[1:0] == 2'b00);
      s2_doy_in  = s1_doy_base_ff + 9'(s1_past_feb_ff && s2_leap_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= req_tvalid;
         end
         if (en2) begin
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && req_tvalid) begin
         s1_cent_ff     <= s1_cent_in;
         s1_year_ff     <= in_year;
         s1_doy_base_ff <= s1_doy_base_in;
         s1_past_feb_ff <= s1_past_feb_in;
         s1_minute_ff   <= in_minute;
         s1_hour_ff     <= in_hour;
         s1_dst_ff      <= in_dst;
      end
      if (en2 && s1_valid_ff) begin
         s2_yy_ff     <= s2_yy_in;
         s2_leap_ff   <= s2_leap_in;
         s2_doy_ff    <= s2_doy_in;
         s2_minute_ff <= s1_minute_ff;
         s2_hour_ff   <= s1_hour_ff;
         s2_dst_ff    <= s1_dst_ff;
      end
   end

   // digit split and frame map
   logic [3:0] min_tens, min_ones, hr_tens, hr_ones;
   logic [1:0] doy_hund;
   logic [6:0] doy_rem;
   logic [3:0] doy_tens, doy_ones, yy_tens, yy_ones;
   logic [8:0] doy_hund_x100;
   logic [wtc_pkg::FRAME_LEN-1:0] ones;

   always_comb begin
      min_tens = wtc_pkg::div10({1'b0, s2_minute_ff});
      min_ones = 4'(7'({1'b0, s2_minute_ff}) - 7'(min_tens) * 7'd10);
      hr_tens  = wtc_pkg::div10({2'b00, s2_hour_ff});
      hr_ones  = 4'(7'({2'b00, s2_hour_ff}) - 7'(hr_tens) * 7'd10);

      if (s2_doy_ff >= 9'd300) begin
         doy_hund = 2'd3;
      end else if (s2_doy_ff >= 9'd200) begin
         doy_hund = 2'd2;
      end else if (s2_doy_ff >= 9'd100) begin
         doy_hund = 2'd1;
      end else begin
         doy_hund = 2'd0;
      end
      doy_hund_x100 = 9'(doy_hund) * 9'd100;
      doy_rem  = 7'(s2_doy_ff - doy_hund_x100);
      doy_tens = wtc_pkg::div10(doy_rem);
      doy_ones = 4'(doy_rem - 7'(doy_tens) * 7'd10);

      yy_tens  = wtc_pkg::div10(s2_yy_ff);
      yy_ones  = 4'(s2_yy_ff - 7'(yy_tens) * 7'd10);

      ones = '0;
      // most significant weight in the earliest second
      ones[1]  = min_tens[2];
      ones[2]  = min_tens[1];
      ones[3]  = min_tens[0];
      ones[5]  = min_ones[3];
      ones[6]  = min_ones[2];
      ones[7]  = min_ones[1];
      ones[8]  = min_ones[0];
      ones[12] = hr_tens[1];
      ones[13] = hr_tens[0];
      ones[15] = hr_ones[3];
      ones[16] = hr_ones[2];
      ones[17] = hr_ones[1];
      ones[18] = hr_ones[0];
      ones[22] = doy_hund[1];
      ones[23] = doy_hund[0];
      ones[25] = doy_tens[3];
      ones[26] = doy_tens[2];
      ones[27] = doy_tens[1];
      ones[28] = doy_tens[0];
      ones[30] = doy_ones[3];
      ones[31] = doy_ones[2];
      ones[32] = doy_ones[1];
      ones[33] = doy_ones[0];
      // UT1 sign positive, correction zero
      ones[36] = 1'b1;
      ones[38] = 1'b1;
      ones[45] = yy_tens[3];
      ones[46] = yy_tens[2];
      ones[47] = yy_tens[1];
      ones[48] = yy_tens[0];
      ones[50] = yy_ones[3];
      ones[51] = yy_ones[2];
      ones[52] = yy_ones[1];
      ones[53] = yy_ones[0];
      ones[55] = s2_leap_ff;
      ones[57] = s2_dst_ff[1];
      ones[58] = s2_dst_ff[0];

      push.valid = push_ok;
      push.ones  = ones;
   end

endmodule

@@ rtl/wtc_queue.sv @@
// ----------------------------------------------------------------------------
// WWVB frame queue
// Short FIFO of frame maps between the front end and the symbol sequencer.
// ----------------------------------------------------------------------------
module wtc_queue #(
   parameter int DEPTH = wtc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  wtc_pkg::frame_type push,
   output logic               full,
   output wtc_pkg::frame_type head,
   input  logic               pop
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [wtc_pkg::FRAME_LEN-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0]              wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]              rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic                          do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && (count_ff != '0);

   assign head.valid = (count_ff != '0);
   assign head.ones  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.ones;
      end
   end

endmodule

@@ rtl/wtc_back.sv @@
// ----------------------------------------------------------------------------
// WWVB symbol sequencer
// Walks the head frame map second by second and drives the result register.
// ----------------------------------------------------------------------------
module wtc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  wtc_pkg::frame_type          head,
   output logic                        pop,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,
   output logic                        rsp_tlast
);

   logic [wtc_pkg::IDX_W-1:0] sec_ff, sec_in;
   logic                      valid_ff, valid_in;
   logic [wtc_pkg::IDX_W-1:0] idx_ff;
   wtc_pkg::symbol_type       sym_ff, sym_in;
   logic [wtc_pkg::MS_W-1:0]  low_ff, low_in, high_ff, high_in;
   logic                      last_ff;
   logic                      load, emit;

   assign load = !valid_ff || rsp_tready;
   assign emit = load && head.valid;
   assign pop  = emit && (sec_ff == wtc_pkg::LAST_SEC);

   always_comb begin
      valid_in = load ? head.valid : valid_ff;
      sec_in   = sec_ff;
      if (emit) begin
         sec_in = (sec_ff == wtc_pkg::LAST_SEC) ? '0 : sec_ff + 1'b1;
      end

      if (wtc_pkg::is_marker(sec_ff)) begin
         sym_in = wtc_pkg::SYM_MARK;
      end else if (head.ones[sec_ff]) begin
         sym_in = wtc_pkg::SYM_ONE;
      end else begin
         sym_in = wtc_pkg::SYM_ZERO;
      end

      unique case (sym_in)
         wtc_pkg::SYM_MARK: begin
            low_in  = wtc_pkg::MS_LONG;
            high_in = wtc_pkg::MS_SHORT;
         end
         wtc_pkg::SYM_ONE: begin
            low_in  = wtc_pkg::MS_HALF;
            high_in = wtc_pkg::MS_HALF;
         end
         default: begin
            low_in  = wtc_pkg::MS_SHORT;
            high_in = wtc_pkg::MS_LONG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sec_ff   <= sec_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         idx_ff  <= sec_ff;
         sym_ff  <= sym_in;
         low_ff  <= low_in;
         high_ff <= high_in;
         last_ff <= (sec_ff == wtc_pkg::LAST_SEC);
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0000, high_ff, low_ff, sym_ff, idx_ff};
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/wwvb_time_code_frame_encoder.sv @@
// A time passes front-end stages 1 and 2 and the frame queue into the result
// register. Throughput: 60 result items per input item, one per cycle while
// rsp_tready is high; the symbol sequencer walking seconds 0..59 sets the rate.
// The front end and a 2-deep frame queue take the next times meanwhile.
// Reset (synchronous, active high) empties the pipeline and queue and
// restarts the sequencer at second 0.
// ----------------------------------------------------------------------------
// WWVB time code frame encoder
// Turns one UTC time into the 60 amplitude-modulated symbols of a frame.
// ----------------------------------------------------------------------------
`include "wwvb_time_code_frame_encoder_defines.svh"

module wwvb_time_code_frame_encoder #(
   parameter int QUEUE_DEPTH = wtc_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // minute_val[5:0], hour_val[10:6], month_index[14:11], day_of_month[19:15],
   // full_year[33:20], dst_status[35:34], zero fill [39:36]
   input  logic [39:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // second_index[5:0], symbol[7:6], low_ms[17:8], high_ms[27:18], zero fill [31:28]
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast
);

   wtc_pkg::frame_type push, head;
   logic               queue_full, pop;

   wtc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .queue_full (queue_full)
   );

   wtc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   wtc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `WTC_ASSERT_SAME(a_last_at_end, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[5:0] == wtc_pkg::LAST_SEC, "tlast not on second 59")

   `WTC_ASSERT_NEXT(a_frame_continues, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && (rsp_tdata[5:0] == $past(rsp_tdata[5:0]) + 6'd1), "frame symbols not contiguous")

   `WTC_ASSERT_SAME(a_marker_pos, clock, reset, rsp_tvalid, (rsp_tdata[7:6] == wtc_pkg::SYM_MARK) == wtc_pkg::is_marker(rsp_tdata[5:0]), "marker at wrong second")

endmodule
